[rtl/core/qfr_pkg.sv]
// Package with the types, character codes and expansion tables of the quote form rewriter.
package qfr_pkg;

    // Character codes that steer the rewrite.
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_OPEN   = 8'h28;
    localparam logic [7:0] CH_CLOSE  = 8'h29;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_APOS   = 8'h27;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;

    // Lengths of the two expansion strings.
    localparam logic [3:0] VECTOR_LEN = 4'd8;
    localparam logic [3:0] QUOTE_LEN  = 4'd7;

    // Entries of the command queue between the front and back parts.
    localparam int QDEPTH = 4;

    typedef enum logic [1:0] {
        MODE_NORMAL,
        MODE_COMMENT,
        MODE_STRING,
        MODE_QUOTE
    } t_mode;

    typedef enum logic [1:0] {
        BODY_NONE,
        BODY_BYTE,
        BODY_VECTOR,
        BODY_QUOTE
    } t_body;

    // One classified input byte: an optional flushed hash, the body, an
    // optional final hash and an optional closing parenthesis.
    typedef struct packed {
        logic       pre_hash;
        t_body      body;
        logic [7:0] data;
        logic       post_hash;
        logic       close;
        logic       last;
    } t_cmd;

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    // Characters of "(vector ".
    function automatic logic [7:0] vector_char(input logic [2:0] idx);
        logic [7:0] ch;
        unique case (idx)
            3'd0: ch = 8'h28;
            3'd1: ch = 8'h76;
            3'd2: ch = 8'h65;
            3'd3: ch = 8'h63;
            3'd4: ch = 8'h74;
            3'd5: ch = 8'h6F;
            3'd6: ch = 8'h72;
            default: ch = 8'h20;
        endcase
        return ch;
    endfunction

    // Characters of "(quote ".
    function automatic logic [7:0] quote_char(input logic [2:0] idx);
        logic [7:0] ch;
        unique case (idx)
            3'd0: ch = 8'h28;
            3'd1: ch = 8'h71;
            3'd2: ch = 8'h75;
            3'd3: ch = 8'h6F;
            3'd4: ch = 8'h74;
            3'd5: ch = 8'h65;
            default: ch = 8'h20;
        endcase
        return ch;
    endfunction

endpackage

[rtl/core/qfr_front.sv]
// Front part: tracks scan mode, quote depth and the held hash, and classifies each byte.
module qfr_front
    import qfr_pkg::*;
#(
    parameter int MAX_DEPTH = 255
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_byte,
    input  logic       i_last,
    output logic       o_push,
    output t_cmd       o_cmd
);

    localparam int DW = $clog2(MAX_DEPTH + 1);
    localparam logic [DW-1:0] DEPTH_MAX = DW'(MAX_DEPTH);

    t_mode         r_mode,  n_mode;
    logic [DW-1:0] r_depth, n_depth;
    logic          r_hash,  n_hash;

    // State after the byte itself, before the end-of-text reset.
    t_mode         w_mode_body;
    logic [DW-1:0] w_depth_body;
    logic          w_hash_body;
    logic          w_vector;

    assign w_vector = r_hash && (i_byte == CH_OPEN);

    // Next state.
    always_comb begin
        w_mode_body  = r_mode;
        w_depth_body = r_depth;
        w_hash_body  = r_hash;
        if (w_vector) begin
            w_hash_body = 1'b0;
            if ((r_mode == MODE_QUOTE) && (r_depth != DEPTH_MAX)) begin
                w_depth_body = r_depth + 1'b1;
            end
        end else begin
            w_hash_body = (i_byte == CH_HASH);
            if (i_byte != CH_HASH) begin
                unique case (r_mode)
                    MODE_COMMENT: begin
                        if (i_byte == CH_NL) w_mode_body = MODE_NORMAL;
                    end
                    MODE_STRING: begin
                        if (i_byte == CH_DQUOTE) w_mode_body = MODE_NORMAL;
                    end
                    MODE_QUOTE: begin
                        if (i_byte == CH_OPEN) begin
                            if (r_depth != DEPTH_MAX) w_depth_body = r_depth + 1'b1;
                        end else if (i_byte == CH_CLOSE) begin
                            if (r_depth == '0) w_mode_body = MODE_NORMAL;
                            else w_depth_body = r_depth - 1'b1;
                        end else if (is_space(i_byte) && (r_depth == '0)) begin
                            w_mode_body = MODE_NORMAL;
                        end
                    end
                    MODE_NORMAL: begin
                        if (i_byte == CH_SEMI) begin
                            w_mode_body = MODE_COMMENT;
                        end else if (i_byte == CH_DQUOTE) begin
                            w_mode_body = MODE_STRING;
                        end else if (i_byte == CH_APOS) begin
                            w_mode_body  = MODE_QUOTE;
                            w_depth_body = '0;
                        end
                    end
                endcase
            end
        end

        n_mode  = r_mode;
        n_depth = r_depth;
        n_hash  = r_hash;
        if (i_accept) begin
            if (i_last) begin
                n_mode  = MODE_NORMAL;
                n_depth = '0;
                n_hash  = 1'b0;
            end else begin
                n_mode  = w_mode_body;
                n_depth = w_depth_body;
                n_hash  = w_hash_body;
            end
        end
    end

    // Command for the back part.
    always_comb begin
        o_cmd           = '0;
        o_cmd.data      = i_byte;
        o_cmd.last      = i_last;
        o_cmd.body      = BODY_NONE;
        if (w_vector) begin
            o_cmd.body = BODY_VECTOR;
        end else begin
            o_cmd.pre_hash = r_hash;
            if (i_byte != CH_HASH) begin
                o_cmd.body = BODY_BYTE;
                unique case (r_mode)
                    MODE_COMMENT, MODE_STRING: ;
                    MODE_QUOTE: begin
                        if ((i_byte == CH_CLOSE) && (r_depth == '0)) begin
                            o_cmd.close = 1'b1;
                        end else if ((i_byte != CH_OPEN) && (i_byte != CH_CLOSE)
                                     && is_space(i_byte) && (r_depth == '0)) begin
                            // Whitespace ending a quote is replaced by the close.
                            o_cmd.data = CH_CLOSE;
                        end
                    end
                    MODE_NORMAL: begin
                        if (i_byte == CH_APOS) o_cmd.body = BODY_QUOTE;
                    end
                endcase
            end
        end
        if (i_last) begin
            o_cmd.post_hash = w_hash_body;
            if (w_mode_body == MODE_QUOTE) o_cmd.close = 1'b1;
        end
        o_push = i_accept && (o_cmd.pre_hash || (o_cmd.body != BODY_NONE)
                              || o_cmd.post_hash || o_cmd.close);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_NORMAL;
            r_depth <= '0;
            r_hash  <= 1'b0;
        end else begin
            r_mode  <= n_mode;
            r_depth <= n_depth;
            r_hash  <= n_hash;
        end
    end

    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_depth <= DEPTH_MAX)
        else $error("quote depth beyond its limit");

    a_last_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_last) |=> ((r_mode == MODE_NORMAL) && !r_hash && (r_depth == '0)))
        else $error("state not cleared after end of text");

    a_last_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_last) |-> o_push)
        else $error("last byte produced no output");

endmodule

[rtl/core/qfr_queue.sv]
// Short command queue between the front and back parts.
module qfr_queue
    import qfr_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_cmd o_cmd
);

    localparam int AW = $clog2(QDEPTH);
    localparam int CW = $clog2(QDEPTH + 1);
    localparam logic [CW-1:0] COUNT_FULL = CW'(QDEPTH);

    t_cmd          r_mem [QDEPTH];
    logic [AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_count,  n_count;
    logic          w_push, w_pop;

    assign o_full  = (r_count == COUNT_FULL);
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = w_push ? AW'(r_wr_ptr + 1'b1) : r_wr_ptr;
        n_rd_ptr = w_pop  ? AW'(r_rd_ptr + 1'b1) : r_rd_ptr;
        n_count  = r_count;
        if (w_push && !w_pop) n_count = r_count + 1'b1;
        else if (!w_push && w_pop) n_count = r_count - 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (w_push) r_mem[r_wr_ptr] <= i_cmd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("push into a full command queue");

endmodule

[rtl/core/qfr_back.sv]
// Back part: expands each queued command into output bytes, one per cycle unless stalled.
module qfr_back
    import qfr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cmd_valid,
    input  t_cmd       i_cmd,
    output logic       o_pop,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_byte,
    output logic       o_run_last,
    output logic       o_text_end
);

    logic [3:0] r_pos, n_pos;
    logic       r_valid, n_valid;
    logic [7:0] r_byte;
    logic       r_run_last;
    logic       r_text_end;

    logic [3:0] w_body_len;
    logic [3:0] w_count;
    logic [3:0] w_body_pos;
    logic [3:0] w_tail_pos;
    logic [7:0] w_byte;
    logic       w_final;
    logic       w_load;

    always_comb begin
        unique case (i_cmd.body)
            BODY_NONE:   w_body_len = 4'd0;
            BODY_BYTE:   w_body_len = 4'd1;
            BODY_VECTOR: w_body_len = VECTOR_LEN;
            BODY_QUOTE:  w_body_len = QUOTE_LEN;
        endcase
        w_count    = 4'(i_cmd.pre_hash) + w_body_len + 4'(i_cmd.post_hash)
                     + 4'(i_cmd.close);
        w_body_pos = r_pos - 4'(i_cmd.pre_hash);
        w_tail_pos = w_body_pos - w_body_len;

        if (i_cmd.pre_hash && (r_pos == 4'd0)) begin
            w_byte = CH_HASH;
        end else if (w_body_pos < w_body_len) begin
            unique case (i_cmd.body)
                BODY_VECTOR: w_byte = vector_char(w_body_pos[2:0]);
                BODY_QUOTE:  w_byte = quote_char(w_body_pos[2:0]);
                BODY_BYTE,
                BODY_NONE:   w_byte = i_cmd.data;
            endcase
        end else if (i_cmd.post_hash && (w_tail_pos == 4'd0)) begin
            w_byte = CH_HASH;
        end else begin
            w_byte = CH_CLOSE;
        end

        w_final = (r_pos == (w_count - 4'd1));
        w_load  = i_cmd_valid && (!r_valid || i_ready);
        o_pop   = w_load && w_final;

        n_pos = r_pos;
        if (w_load) n_pos = w_final ? 4'd0 : (r_pos + 4'd1);
        n_valid = w_load || (r_valid && !i_ready);
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_byte     <= w_byte;
            r_run_last <= w_final;
            r_text_end <= w_final && i_cmd.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= 4'd0;
            r_valid <= 1'b0;
        end else begin
            r_pos   <= n_pos;
            r_valid <= n_valid;
        end
    end

    assign o_valid    = r_valid;
    assign o_byte     = r_byte;
    assign o_run_last = r_run_last;
    assign o_text_end = r_text_end;

    a_pos_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd_valid |-> (r_pos < w_count))
        else $error("expansion position past end of command");

endmodule

[rtl/core/quote_form_rewriter.sv]
// Top level of the quote form rewriter: front classifier, command queue and byte expander.
//
// The block reads Lisp source text on the slave stream, one byte per transaction,
// with tlast on the final byte of a text, and writes the rewritten text on the
// master stream. An apostrophe datum becomes "(quote datum)" and "#(" becomes
// "(vector ", also inside comments and strings, which otherwise pass through.
// On the master side tuser marks the last byte produced by one input byte and
// tlast the last byte of a text. A byte accepted on the slave side passes through
// the command queue and the output register before its first output byte appears.
// Throughput is one output byte per cycle while the master side is ready, set by
// the expander in the back part. A byte that maps to one output byte lets the
// input run at one byte per cycle when no stall holds it; an expansion gives up
// to nine output bytes, and a four-entry command queue absorbs that while the front keeps
// taking input until the queue is full. A held hash that is not last produces no output.
// When the receiver stalls, the output register holds its transaction, the
// expander stops, and the queue fills before tready drops on the input side.
// Synchronous reset clears the scan state, the queue and the output valid flag.
module quote_form_rewriter
    import qfr_pkg::*;
#(
    parameter int MAX_DEPTH = 255
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,  // [7:0] text_byte
    input  logic       i_s_axis_tlast,  // text_last
    output logic       o_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata,  // [7:0] out_byte
    output logic       o_m_axis_tuser,  // [0] run_last
    output logic       o_m_axis_tlast   // text_end
);

    logic w_accept;
    logic w_push;
    t_cmd w_push_cmd;
    logic w_full;
    logic w_pop;
    logic w_head_valid;
    t_cmd w_head_cmd;

    // Input is taken whenever the command queue has room.
    assign o_s_axis_tready = !w_full;
    assign w_accept        = i_s_axis_tvalid && !w_full;

    qfr_front #(
        .MAX_DEPTH (MAX_DEPTH)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_byte   (i_s_axis_tdata),
        .i_last   (i_s_axis_tlast),
        .o_push   (w_push),
        .o_cmd    (w_push_cmd)
    );

    qfr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_head_valid),
        .o_cmd   (w_head_cmd)
    );

    qfr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_head_valid),
        .i_cmd       (w_head_cmd),
        .o_pop       (w_pop),
        .o_valid     (o_m_axis_tvalid),
        .i_ready     (i_m_axis_tready),
        .o_byte      (o_m_axis_tdata),
        .o_run_last  (o_m_axis_tuser),
        .o_text_end  (o_m_axis_tlast)
    );

endmodule
